// ----- rtl/fcr_pkg.sv -----
// shared constants, handshake types and the crc-16 byte update for the frame responder
package fcr_pkg;

  // largest payload a received frame may carry
  localparam int MAX_PAYLOAD = 8;
  localparam int PAY_CNT_W   = $clog2(MAX_PAYLOAD + 1);

  // frame bytes
  localparam logic [7:0]  SOF_BYTE     = 8'hAA;
  localparam logic [7:0]  ID_TIME      = 8'h05;
  localparam logic [7:0]  ID_ACK       = 8'h81;
  localparam logic [7:0]  ID_NACK      = 8'h82;
  localparam logic [7:0]  ID_TIME_RESP = 8'h83;
  localparam logic [7:0]  ID_ACT_FIRST = 8'h01;
  localparam logic [7:0]  ID_ACT_LAST  = 8'h04;
  localparam logic [15:0] YEAR_BASE    = 16'd2000;

  // crc-16/modbus
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // response geometry
  localparam int          RESP_IDX_W     = 4;
  localparam logic [3:0]  RESP_LEN_SHORT = 4'd6;
  localparam logic [3:0]  RESP_LEN_TIME  = 4'd12;
  localparam logic [7:0]  PAY_LEN_SHORT  = 8'd1;
  localparam logic [7:0]  PAY_LEN_TIME   = 8'd7;

  // controller to datapath
  typedef struct packed {
    logic rx_take;    // request accepted on the input side
    logic resp_load;  // accepted byte completes a good frame
    logic tx_take;    // response byte accepted downstream
  } fcr_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic frame_done; // current input byte would close a frame with matching crc
    logic resp_last;  // response byte on show is the final one
  } fcr_stat_t;

  // one byte through the reflected crc, bit by bit
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ----- rtl/fcr_ctrl.sv -----
// controller: receive or transmit mode, drives the handshakes and datapath commands
module fcr_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  output logic             out_tvalid,
  input  logic             out_tready,
  input  fcr_pkg::fcr_stat_t stat,
  output fcr_pkg::fcr_cmd_t  cmd
);

  typedef enum logic [0:0] {ST_RX, ST_TX} state_t;

  state_t state_r, state_nxt;
  logic   in_tready_r, in_tready_nxt;
  logic   out_tvalid_r, out_tvalid_nxt;

  // commands follow the handshakes
  always_comb begin
    cmd.rx_take   = in_tvalid & in_tready_r;
    cmd.resp_load = cmd.rx_take & stat.frame_done;
    cmd.tx_take   = out_tvalid_r & out_tready;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_RX: begin
        if (cmd.resp_load) state_nxt = ST_TX;
      end
      ST_TX: begin
        if (cmd.tx_take && stat.resp_last) state_nxt = ST_RX;
      end
      default: state_nxt = ST_RX;
    endcase
    in_tready_nxt  = (state_nxt == ST_RX);
    out_tvalid_nxt = (state_nxt == ST_TX);
  end

  // state and registered handshake outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_RX;
      in_tready_r  <= 1'b1;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      in_tready_r  <= in_tready_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  assign in_tready  = in_tready_r;
  assign out_tvalid = out_tvalid_r;

endmodule

// ----- rtl/fcr_dp.sv -----
// datapath: frame parser, running crc, response byte builder with its own crc
module fcr_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  fcr_pkg::fcr_cmd_t cmd,
  output fcr_pkg::fcr_stat_t stat,
  input  logic [7:0]        rx_data,
  input  logic [7:0]        year_offset,
  input  logic [3:0]        month_now,
  input  logic [4:0]        day_now,
  input  logic [4:0]        hour_now,
  input  logic [5:0]        minute_now,
  input  logic [5:0]        second_now,
  output logic [7:0]        tx_data,
  output logic              last_byte,
  output logic [2:0]        action
);

  typedef enum logic [2:0] {
    PH_SOF  = 3'd0,
    PH_ID   = 3'd1,
    PH_LEN  = 3'd2,
    PH_PAY  = 3'd3,
    PH_CRCH = 3'd4,
    PH_CRCL = 3'd5
  } phase_t;

  typedef enum logic [1:0] {RK_ACK, RK_NACK, RK_TIME} resp_kind_t;

  // receive side
  phase_t                        phase_r, phase_nxt;
  logic [7:0]                    frame_id_r, frame_id_nxt;
  logic [fcr_pkg::PAY_CNT_W-1:0] frame_len_r, frame_len_nxt;
  logic [fcr_pkg::PAY_CNT_W-1:0] pay_cnt_r, pay_cnt_nxt;
  logic [7:0]                    crc_hi_r, crc_hi_nxt;
  logic [15:0]                   run_crc_r, run_crc_nxt;
  logic [15:0]                   crc_upd;

  // transmit side
  resp_kind_t                     kind_r;
  logic [7:0]                     rid_r;
  logic [15:0]                    year_r;
  logic [3:0]                     mon_r;
  logic [4:0]                     day_r;
  logic [4:0]                     hr_r;
  logic [5:0]                     min_r;
  logic [5:0]                     sec_r;
  logic [fcr_pkg::RESP_IDX_W-1:0] idx_r;
  logic [15:0]                    tx_crc_r;
  logic [fcr_pkg::RESP_IDX_W-1:0] resp_len;
  logic [7:0]                     body_byte;

  assign crc_upd = fcr_pkg::crc_byte((phase_r == PH_ID) ? fcr_pkg::CRC_INIT : run_crc_r,
                                     rx_data);

  // good frame when the low crc byte completes a match
  assign stat.frame_done = (phase_r == PH_CRCL) && ({crc_hi_r, rx_data} == run_crc_r);

  // parser next state
  always_comb begin
    phase_nxt     = phase_r;
    frame_id_nxt  = frame_id_r;
    frame_len_nxt = frame_len_r;
    pay_cnt_nxt   = pay_cnt_r;
    crc_hi_nxt    = crc_hi_r;
    run_crc_nxt   = run_crc_r;
    case (phase_r)
      PH_ID: begin
        frame_id_nxt = rx_data;
        run_crc_nxt  = crc_upd;
        phase_nxt    = PH_LEN;
      end
      PH_LEN: begin
        frame_len_nxt = rx_data[fcr_pkg::PAY_CNT_W-1:0];
        pay_cnt_nxt   = '0;
        run_crc_nxt   = crc_upd;
        if (rx_data > 8'(fcr_pkg::MAX_PAYLOAD)) phase_nxt = PH_SOF;
        else if (rx_data != 8'd0) phase_nxt = PH_PAY;
        else phase_nxt = PH_CRCH;
      end
      PH_PAY: begin
        pay_cnt_nxt = pay_cnt_r + 1'b1;
        run_crc_nxt = crc_upd;
        if (pay_cnt_nxt >= frame_len_r) phase_nxt = PH_CRCH;
      end
      PH_CRCH: begin
        crc_hi_nxt = rx_data;
        phase_nxt  = PH_CRCL;
      end
      PH_CRCL: begin
        phase_nxt = PH_SOF;
      end
      default: begin
        phase_nxt = (rx_data == fcr_pkg::SOF_BYTE) ? PH_ID : PH_SOF;
      end
    endcase
  end

  // parser registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_SOF;
      frame_id_r  <= '0;
      frame_len_r <= '0;
      pay_cnt_r   <= '0;
      crc_hi_r    <= '0;
      run_crc_r   <= fcr_pkg::CRC_INIT;
    end else if (cmd.rx_take) begin
      phase_r     <= phase_nxt;
      frame_id_r  <= frame_id_nxt;
      frame_len_r <= frame_len_nxt;
      pay_cnt_r   <= pay_cnt_nxt;
      crc_hi_r    <= crc_hi_nxt;
      run_crc_r   <= run_crc_nxt;
    end
  end

  // response contents, captured with the closing byte
  always_ff @(posedge clk) begin
    if (cmd.resp_load) begin
      rid_r  <= frame_id_r;
      year_r <= fcr_pkg::YEAR_BASE + {8'h00, year_offset};
      mon_r  <= month_now;
      day_r  <= day_now;
      hr_r   <= hour_now;
      min_r  <= minute_now;
      sec_r  <= second_now;
      if (frame_id_r == fcr_pkg::ID_TIME) kind_r <= RK_TIME;
      else if (frame_id_r >= fcr_pkg::ID_ACT_FIRST && frame_id_r <= fcr_pkg::ID_ACT_LAST)
        kind_r <= RK_ACK;
      else kind_r <= RK_NACK;
    end
  end

  assign resp_len = (kind_r == RK_TIME) ? fcr_pkg::RESP_LEN_TIME : fcr_pkg::RESP_LEN_SHORT;

  // header and body bytes by position
  always_comb begin
    case (idx_r)
      4'd0: body_byte = fcr_pkg::SOF_BYTE;
      4'd1: begin
        case (kind_r)
          RK_ACK:  body_byte = fcr_pkg::ID_ACK;
          RK_TIME: body_byte = fcr_pkg::ID_TIME_RESP;
          default: body_byte = fcr_pkg::ID_NACK;
        endcase
      end
      4'd2: body_byte = (kind_r == RK_TIME) ? fcr_pkg::PAY_LEN_TIME : fcr_pkg::PAY_LEN_SHORT;
      4'd3: body_byte = (kind_r == RK_TIME) ? year_r[15:8] : rid_r;
      4'd4: body_byte = year_r[7:0];
      4'd5: body_byte = {4'h0, mon_r};
      4'd6: body_byte = {3'h0, day_r};
      4'd7: body_byte = {3'h0, hr_r};
      4'd8: body_byte = {2'h0, min_r};
      4'd9: body_byte = {2'h0, sec_r};
      default: body_byte = 8'h00;
    endcase
  end

  // crc bytes close the frame
  always_comb begin
    if (idx_r == resp_len - 4'd2) tx_data = tx_crc_r[15:8];
    else if (idx_r == resp_len - 4'd1) tx_data = tx_crc_r[7:0];
    else tx_data = body_byte;
  end

  assign last_byte      = (idx_r == resp_len - 4'd1);
  assign stat.resp_last = last_byte;
  assign action         = (idx_r == 4'd0 && kind_r == RK_ACK) ? rid_r[2:0] : 3'd0;

  // byte position and transmit crc over id, length and payload
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r    <= '0;
      tx_crc_r <= fcr_pkg::CRC_INIT;
    end else if (cmd.resp_load) begin
      idx_r    <= '0;
      tx_crc_r <= fcr_pkg::CRC_INIT;
    end else if (cmd.tx_take) begin
      idx_r <= idx_r + 1'b1;
      if (idx_r != 4'd0 && idx_r < resp_len - 4'd2)
        tx_crc_r <= fcr_pkg::crc_byte(tx_crc_r, body_byte);
    end
  end

endmodule

// ----- rtl/framed_command_responder_top.sv -----
// top level of the framed command responder: controller plus datapath
//
// channel   direction  tdata fields (lsb up)                            side
// in_*      input      rx_data, year_offset, month, day, hour, min, sec -
// out_*     output     tx_data, action                                  tlast = last byte
//
// one received byte is taken per cycle while no response is pending; the parser
// and its crc update complete in that cycle. a good frame then sends 6 bytes
// (ack, nack) or 12 bytes (time), one per cycle at best, the sequencer stepping
// on each accepted byte; input is held off until the last byte leaves.
// reset: synchronous, active low, parser waits for a start byte.
// output stalls hold the byte on show steady.
module framed_command_responder_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [7:0] rx_data, [15:8] year_offset, [19:16] month_now, [24:20] day_now,
  // [29:25] hour_now, [35:30] minute_now, [41:36] second_now, [47:42] zero
  input  logic [47:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [7:0] tx_data, [10:8] action, [15:11] zero
  output logic [15:0] out_tdata,
  output logic        out_tlast
);

  fcr_pkg::fcr_cmd_t  cmd;
  fcr_pkg::fcr_stat_t stat;
  logic [7:0]         tx_data;
  logic [2:0]         action;

  // handshake control
  fcr_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  // parser and response builder
  fcr_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .rx_data     (in_tdata[7:0]),
    .year_offset (in_tdata[15:8]),
    .month_now   (in_tdata[19:16]),
    .day_now     (in_tdata[24:20]),
    .hour_now    (in_tdata[29:25]),
    .minute_now  (in_tdata[35:30]),
    .second_now  (in_tdata[41:36]),
    .tx_data     (tx_data),
    .last_byte   (out_tlast),
    .action      (action)
  );

  assign out_tdata = {5'b00000, action, tx_data};

endmodule

// ----- test/framed_command_responder_top_test.sv -----
// self-checking testbench for the framed command responder: frames in, response bytes out
module framed_command_responder_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT_CYCLES = 400000;
  localparam int RANDOM_ITEMS = 75;

  // receive parser phases
  typedef enum logic [2:0] {RX_SOF, RX_ID, RX_LEN, RX_PAY, RX_CRCH, RX_CRCL} rx_phase_t;

  // time of day as it sits in tdata above the received byte
  typedef struct packed {
    logic [5:0] sc;
    logic [5:0] mn;
    logic [4:0] hr;
    logic [4:0] dy;
    logic [3:0] mo;
    logic [7:0] yr;
  } tod_t;

  // one expected response byte
  typedef struct {
    logic [7:0] data;
    logic       last;
    logic [2:0] act;
  } reply_byte_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        out_tlast;

  framed_command_responder_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always #4 clk = ~clk;

  // expected response bytes, oldest first
  reply_byte_t reply_q[$];

  // parser copy kept by the predictor
  rx_phase_t   rx_phase = RX_SOF;
  logic [7:0]  rx_id = '0;
  logic [7:0]  rx_len = '0;
  int          rx_count = 0;
  logic [7:0]  rx_crc_hi = '0;
  logic [15:0] rx_crc = 16'hFFFF;

  // run statistics
  int mismatches = 0;
  int requests_sent = 0;
  int bytes_checked = 0;
  int acks = 0;
  int times = 0;
  int nacks = 0;
  int crc_drops = 0;
  int oversized = 0;
  int cycles = 0;

  // stimulus controls
  bit   steady = 1'b0;
  bit   vary_clock = 1'b1;
  tod_t clock_now = '0;
  int   hold_off_req = 0;
  int   hold_left = 0;

  // crc-16/modbus, one byte
  function automatic logic [15:0] crc16_step(input logic [15:0] c, input logic [7:0] d);
    logic [15:0] r;
    r = c ^ {8'h00, d};
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? ((r >> 1) ^ 16'hA001) : (r >> 1);
    end
    return r;
  endfunction

  // queue a whole response frame: start, code, length, body, crc high, crc low
  function automatic void queue_reply(input logic [7:0] code, input int n,
                                      input logic [55:0] body, input logic [2:0] act);
    logic [95:0] seq;
    logic [15:0] c;
    reply_byte_t rb;
    seq = '0;
    seq[7:0] = fcr_pkg::SOF_BYTE;
    seq[15:8] = code;
    seq[23:16] = 8'(n);
    c = crc16_step(crc16_step(16'hFFFF, code), 8'(n));
    for (int k = 0; k < n; k++) begin
      seq[8*(k+3) +: 8] = body[8*k +: 8];
      c = crc16_step(c, body[8*k +: 8]);
    end
    seq[8*(n+3) +: 8] = c[15:8];
    seq[8*(n+4) +: 8] = c[7:0];
    for (int k = 0; k < n + 5; k++) begin
      rb.data = seq[8*k +: 8];
      rb.last = (k == n + 4);
      rb.act  = (k == 0) ? act : 3'd0;
      reply_q.push_back(rb);
    end
  endfunction

  // parser step on one accepted request
  function automatic void predict_rx_byte(input logic [47:0] req);
    logic [7:0]  b;
    tod_t        t;
    logic [15:0] yr16;
    logic [55:0] body;
    b = req[7:0];
    t = req[41:8];
    case (rx_phase)
      RX_ID: begin
        rx_id = b;
        rx_crc = crc16_step(16'hFFFF, b);
        rx_phase = RX_LEN;
      end
      RX_LEN: begin
        rx_len = b;
        rx_count = 0;
        rx_crc = crc16_step(rx_crc, b);
        if (b > fcr_pkg::MAX_PAYLOAD) begin
          rx_phase = RX_SOF;
          oversized++;
        end else if (b != 8'd0) begin
          rx_phase = RX_PAY;
        end else begin
          rx_phase = RX_CRCH;
        end
      end
      RX_PAY: begin
        rx_count++;
        rx_crc = crc16_step(rx_crc, b);
        if (rx_count >= rx_len) rx_phase = RX_CRCH;
      end
      RX_CRCH: begin
        rx_crc_hi = b;
        rx_phase = RX_CRCL;
      end
      RX_CRCL: begin
        rx_phase = RX_SOF;
        if ({rx_crc_hi, b} != rx_crc) begin
          crc_drops++;
        end else if (rx_id >= fcr_pkg::ID_ACT_FIRST && rx_id <= fcr_pkg::ID_ACT_LAST) begin
          queue_reply(fcr_pkg::ID_ACK, 1, {48'd0, rx_id}, rx_id[2:0]);
          acks++;
        end else if (rx_id == fcr_pkg::ID_TIME) begin
          yr16 = fcr_pkg::YEAR_BASE + {8'd0, t.yr};
          body = {2'b0, t.sc, 2'b0, t.mn, 3'b0, t.hr, 3'b0, t.dy, 4'b0, t.mo,
                  yr16[7:0], yr16[15:8]};
          queue_reply(fcr_pkg::ID_TIME_RESP, 7, body, 3'd0);
          times++;
        end else begin
          queue_reply(fcr_pkg::ID_NACK, 1, {48'd0, rx_id}, 3'd0);
          nacks++;
        end
      end
      default: begin
        rx_phase = (b == fcr_pkg::SOF_BYTE) ? RX_ID : RX_SOF;
      end
    endcase
  endfunction

  // compare one accepted response byte with the oldest expectation
  function automatic void check_reply_byte();
    reply_byte_t exp_b;
    if (reply_q.size() == 0) begin
      $display("%0t: response byte %h with nothing expected", $time, out_tdata[7:0]);
      mismatches++;
      return;
    end
    exp_b = reply_q.pop_front();
    bytes_checked++;
    if (out_tdata[7:0] !== exp_b.data) begin
      $display("%0t: tx_data expected %h actual %h", $time, exp_b.data, out_tdata[7:0]);
      mismatches++;
    end
    if (out_tlast !== exp_b.last) begin
      $display("%0t: last_byte expected %b actual %b", $time, exp_b.last, out_tlast);
      mismatches++;
    end
    if (out_tdata[10:8] !== exp_b.act) begin
      $display("%0t: action expected %0d actual %0d", $time, exp_b.act, out_tdata[10:8]);
      mismatches++;
    end
  endfunction

  // prediction then checking, both on the same edge values
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) predict_rx_byte(in_tdata);
    if (rst_n && out_tvalid && out_tready) check_reply_byte();
  end

  // receiver pacing, with the long hold-off counted here
  always @(posedge clk) begin : rx_pace
    int pick;
    pick = $urandom_range(0, 99);
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_off_req > 0) begin
      out_tready <= 1'b0;
      hold_left <= hold_off_req - 1;
      hold_off_req = 0;
    end else if (!steady && pick < 12) begin
      out_tready <= 1'b0;
      hold_left <= $urandom_range(0, 2);
    end else if (!steady && pick < 14) begin
      out_tready <= 1'b0;
      hold_left <= $urandom_range(10, 40);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("%0t: timeout after %0d cycles", $time, cycles);
      $display("** framed_command_responder_top: FAILED **");
      $finish;
    end
  end

  function automatic int pick_span(input int lo, input int hi);
    case ($urandom_range(0, 3))
      0: return lo;
      1: return hi;
      default: return $urandom_range(lo, hi);
    endcase
  endfunction

  // offer one request, after an optional gap, and wait for its acceptance
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = 0;
    if (!steady) begin
      case ($urandom_range(0, 19))
        0: gap = $urandom_range(10, 30);
        1, 2, 3, 4, 5: gap = $urandom_range(1, 3);
        default: gap = 0;
      endcase
    end
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    if (vary_clock) begin
      clock_now.yr = 8'(pick_span(0, 255));
      clock_now.mo = 4'(pick_span(1, 12));
      clock_now.dy = 5'(pick_span(1, 31));
      clock_now.hr = 5'(pick_span(0, 23));
      clock_now.mn = 6'(pick_span(0, 59));
      clock_now.sc = 6'(pick_span(0, 59));
    end
    in_tvalid <= 1'b1;
    in_tdata <= {6'b0, clock_now, b};
    do @(posedge clk); while (!in_tready);
    requests_sent++;
  endtask

  // whole frame, optionally with one crc bit flipped
  task automatic send_frame(input logic [7:0] id, input int len, input logic [63:0] pay,
                            input bit corrupt);
    logic [15:0] c;
    c = crc16_step(crc16_step(16'hFFFF, id), 8'(len));
    for (int k = 0; k < len; k++) c = crc16_step(c, pay[8*k +: 8]);
    if (corrupt) c = c ^ (16'd1 << $urandom_range(0, 15));
    send_byte(fcr_pkg::SOF_BYTE);
    send_byte(id);
    send_byte(8'(len));
    for (int k = 0; k < len; k++) send_byte(pay[8*k +: 8]);
    send_byte(c[15:8]);
    send_byte(c[7:0]);
  endtask

  function automatic logic [63:0] random_payload();
    logic [63:0] p;
    for (int k = 0; k < 8; k++) begin
      p[8*k +: 8] = ($urandom_range(0, 9) == 0) ? fcr_pkg::SOF_BYTE : 8'($urandom);
    end
    return p;
  endfunction

  // line noise, then an ack for the lowest action id with no payload
  task automatic test_ack_frame();
    send_byte(8'h00);
    send_frame(fcr_pkg::ID_ACT_FIRST, 0, '0, 1'b0);
  endtask

  // time request with every time field at its top value
  task automatic test_time_reply();
    vary_clock = 1'b0;
    clock_now = '{sc: 6'd59, mn: 6'd59, hr: 5'd23, dy: 5'd31, mo: 4'd12, yr: 8'd255};
    send_frame(fcr_pkg::ID_TIME, 0, '0, 1'b0);
    vary_clock = 1'b1;
  endtask

  // unknown id gets a nack; a start byte inside the payload is plain data
  task automatic test_nack_start_in_payload();
    send_frame(8'hFF, 1, {56'd0, fcr_pkg::SOF_BYTE}, 1'b0);
  endtask

  // length above the payload limit resynchronises the parser
  task automatic test_oversized_length();
    send_byte(fcr_pkg::SOF_BYTE);
    send_byte(8'h11);
    send_byte(8'(fcr_pkg::MAX_PAYLOAD + 1));
  endtask

  // a bad crc drops the frame with no response
  task automatic test_crc_mismatch();
    send_frame(8'h02, 0, '0, 1'b1);
  endtask

  // mostly good frames with random content, some broken ones and noise
  task automatic test_random_traffic();
    int stop_at;
    int kind;
    int len;
    logic [7:0] id;
    stop_at = requests_sent + RANDOM_ITEMS;
    while (requests_sent < stop_at) begin
      kind = $urandom_range(0, 99);
      id = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(1, 5)) : 8'($urandom);
      case ($urandom_range(0, 6))
        0: len = 0;
        1: len = fcr_pkg::MAX_PAYLOAD;
        default: len = $urandom_range(1, fcr_pkg::MAX_PAYLOAD - 1);
      endcase
      if (kind < 75) begin
        send_frame(id, len, random_payload(), $urandom_range(0, 9) == 0);
      end else if (kind < 85) begin
        send_byte(fcr_pkg::SOF_BYTE);
        send_byte(id);
        send_byte(($urandom_range(0, 3) == 0) ? 8'hFF
                  : 8'($urandom_range(fcr_pkg::MAX_PAYLOAD + 1, 255)));
      end else if (kind < 93) begin
        // cut short: what follows lands in the middle of this frame
        send_byte(fcr_pkg::SOF_BYTE);
        send_byte(id);
        send_byte(8'(len));
        repeat ($urandom_range(0, len)) send_byte(8'($urandom));
      end else begin
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
      end
    end
  endtask

  // receiver holds off for a long stretch while frames keep coming
  task automatic test_output_hold_off();
    steady = 1'b1;
    hold_off_req = 300;
    send_frame(8'h03, 0, '0, 1'b0);
    send_frame(fcr_pkg::ID_TIME, 2, random_payload(), 1'b0);
    send_frame(8'h04, 1, random_payload(), 1'b0);
    steady = 1'b0;
  endtask

  // frames back to back with no idling on either side
  task automatic test_back_to_back();
    steady = 1'b1;
    for (int k = 1; k <= 6; k++) send_frame(8'(k), k % 3, random_payload(), 1'b0);
    steady = 1'b0;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_ack_frame();
    test_time_reply();
    test_nack_start_in_payload();
    test_oversized_length();
    test_crc_mismatch();
    test_random_traffic();
    test_output_hold_off();
    test_back_to_back();
    in_tvalid <= 1'b0;
    while (reply_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("run covered %0d requests: %0d ack, %0d time and %0d nack responses",
             requests_sent, acks, times, nacks);
    $display("%0d frames dropped on crc, %0d oversized lengths, %0d response bytes checked",
             crc_drops, oversized, bytes_checked);
    if (mismatches == 0) begin
      $display("** framed_command_responder_top: PASSED **");
    end else begin
      $display("** framed_command_responder_top: FAILED **");
    end
    $finish;
  end

endmodule
